>>> design/buddy_page_allocator_macros.svh
// Assertion macros for the buddy page allocator.
// Used by the top level only; compiled out when SYNTHESIS is defined.
`ifndef BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define BPA_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define BPA_ASSERT_IMP(label, clk, rst_n, a, c)
`define BPA_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

>>> design/bpa_pkg.sv
// Shared constants for the buddy page allocator.
// No dependencies.
`default_nettype none
package bpa_pkg;
	localparam int DEF_MAX_ORDER  = 10;
	localparam int DEF_TOP_BLOCKS = 8;
	localparam int ORDER_W  = 4;
	localparam int PAGE_W   = 13;
	localparam int STATUS_W = 3;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_MEM      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_ORDER   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_ALLOC   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ORDER_MISM  = 3'd4;
endpackage
`default_nettype wire

>>> design/bpa_page_ram.sv
// Per-page state memory: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none
module bpa_page_ram #(
	parameter int DEPTH = 8192,
	parameter int WIDTH = 34
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

>>> design/buddy_page_allocator.sv
// channel | direction | handshake              | payload
// request | in        | start && !busy         | op, order, page_index
// result  | out       | done (one cycle)       | status, block_index
// Sequencer over one page-state memory (registered read data), free-list
// heads and counts in flops; done shows in the cycle after the last state.
// Allocate: search upward from the requested order for a free block, unlink it,
// split down to the requested order pushing upper halves, finish. Free: check,
// merge with free equal-order buddies, push. Bad order/page: answered from idle.
// After reset, clearing all TOP_BLOCKS<<MAX_ORDER pages holds busy high.
// The result receiver cannot stall; a new request may be taken as done shows.
// Depends on bpa_pkg, bpa_page_ram, buddy_page_allocator_macros.svh.
`default_nettype none
`include "buddy_page_allocator_macros.svh"
module buddy_page_allocator #(
	parameter int MAX_ORDER  = bpa_pkg::DEF_MAX_ORDER,
	parameter int TOP_BLOCKS = bpa_pkg::DEF_TOP_BLOCKS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic                           op,
	input  wire logic [bpa_pkg::ORDER_W-1:0]    order,
	input  wire logic [bpa_pkg::PAGE_W-1:0]     page_index,
	output logic                                done,
	output logic      [bpa_pkg::STATUS_W-1:0]   status,
	output logic      [bpa_pkg::PAGE_W-1:0]     block_index
);
	import bpa_pkg::*;

	localparam int NPAGES = TOP_BLOCKS << MAX_ORDER;
	localparam int NORD   = MAX_ORDER + 1;
	localparam int PW     = $clog2(NPAGES);
	localparam int LW     = PW + 1;
	localparam int IW     = $clog2(NORD);
	localparam int OW     = $clog2(NORD + 1);
	localparam int MW     = 2 + ORDER_W + 2 * LW;
	localparam logic [LW-1:0] NIL     = LW'(NPAGES);
	localparam logic [LW-1:0] TOPSTEP = LW'(1) << MAX_ORDER;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_SEARCH, S_UL_RD, S_UL_A, S_UL_PW, S_UL_N, S_UL_NW,
		S_UL_FIN, S_SPLIT, S_PUSH, S_PUSH_W, S_FCHK, S_MERGE, S_MCHK
	} state_t;

	state_t             state_q;
	logic [PW-1:0]      init_q;
	logic [OW-1:0]      cur_q;
	logic [OW-1:0]      req_q;
	logic               alloc_q;
	logic [LW-1:0]      blk_q;
	logic [LW-1:0]      u_pg_q;
	logic [LW-1:0]      u_prv_q;
	logic [LW-1:0]      u_nxt_q;
	logic [LW-1:0]      push_pg_q;
	logic [LW-1:0]      push_old_q;
	logic [LW-1:0]      head_q [NORD];
	logic [LW-1:0]      cnt_q  [NORD];
	logic               done_q;
	logic [STATUS_W-1:0] status_q;
	logic [PAGE_W-1:0]  bidx_q;

	// memory port
	logic               we, re;
	logic [PW-1:0]      waddr, raddr;
	logic [MW-1:0]      wdata, rdata;

	bpa_page_ram #(.DEPTH(NPAGES), .WIDTH(MW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.re(re), .raddr(raddr), .rdata(rdata)
	);

	// read word fields
	logic               rd_iu, rd_fh;
	logic [ORDER_W-1:0] rd_ord;
	logic [LW-1:0]      rd_nxt, rd_prv;
	assign {rd_iu, rd_fh, rd_ord, rd_nxt, rd_prv} = rdata;

	logic [IW-1:0]        cidx;
	logic [OW+ORDER_W-1:0] cur_x, rdord_x, inord_x;
	logic [ORDER_W-1:0]   cur4, req4;
	logic [OW+ORDER_W-1:0] req_x;
	logic [LW+PAGE_W-1:0] pg_x;
	logic [LW-1:0]        pg_l;
	logic [LW+PAGE_W-1:0] blk_x;
	logic                 ord_bad, pg_bad, ord_match;
	logic [LW-1:0]        cur_bit, bud, head_c, cnt_c;
	logic [LW-1:0]        init_l;
	logic                 init_head, init_first, init_last;

	assign cidx      = cur_q[IW-1:0];
	assign cur_x     = {{ORDER_W{1'b0}}, cur_q};
	assign req_x     = {{ORDER_W{1'b0}}, req_q};
	assign cur4      = cur_x[ORDER_W-1:0];
	assign req4      = req_x[ORDER_W-1:0];
	assign rdord_x   = {{OW{1'b0}}, rd_ord};
	assign inord_x   = {{OW{1'b0}}, order};
	assign ord_bad   = inord_x > (OW + ORDER_W)'(MAX_ORDER);
	assign pg_x      = {{LW{1'b0}}, page_index};
	assign pg_bad    = pg_x >= (LW + PAGE_W)'(NPAGES);
	assign pg_l      = pg_x[LW-1:0];
	assign ord_match = rdord_x == cur_x;
	assign cur_bit   = LW'(1) << cur_q;
	assign bud       = blk_q ^ cur_bit;
	assign head_c    = head_q[cidx];
	assign cnt_c     = cnt_q[cidx];
	assign blk_x     = {{PAGE_W{1'b0}}, blk_q};

	assign init_l     = {1'b0, init_q};
	assign init_head  = (init_l & (TOPSTEP - LW'(1))) == '0;
	assign init_first = init_l < TOPSTEP;
	assign init_last  = init_l >= NIL - TOPSTEP;

	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = '0;
		raddr = '0;
		wdata = '0;
		unique case (state_q)
			S_INIT: begin
				we    = 1'b1;
				waddr = init_q;
				if (init_head) begin
					wdata = {1'b0, 1'b1, ORDER_W'(MAX_ORDER),
						init_last ? NIL : init_l + TOPSTEP,
						init_first ? NIL : init_l - TOPSTEP};
				end else begin
					wdata = {1'b0, 1'b0, {ORDER_W{1'b0}}, NIL, NIL};
				end
			end
			S_IDLE: begin
				if (start && op == OP_FREE && !ord_bad && !pg_bad) begin
					re    = 1'b1;
					raddr = pg_l[PW-1:0];
				end
			end
			S_UL_RD: begin
				re    = 1'b1;
				raddr = u_pg_q[PW-1:0];
			end
			S_UL_A: begin
				if (rd_prv < NIL) begin
					re    = 1'b1;
					raddr = rd_prv[PW-1:0];
				end
			end
			S_UL_PW: begin
				we    = 1'b1;
				waddr = u_prv_q[PW-1:0];
				wdata = {rd_iu, rd_fh, rd_ord, u_nxt_q, rd_prv};
			end
			S_UL_N: begin
				if (u_nxt_q < NIL) begin
					re    = 1'b1;
					raddr = u_nxt_q[PW-1:0];
				end
			end
			S_UL_NW: begin
				we    = 1'b1;
				waddr = u_nxt_q[PW-1:0];
				wdata = {rd_iu, rd_fh, rd_ord, rd_nxt, u_prv_q};
			end
			S_UL_FIN: begin
				we    = 1'b1;
				waddr = u_pg_q[PW-1:0];
				if (alloc_q) begin
					wdata = {1'b1, 1'b0, req4, NIL, NIL};
				end else begin
					wdata = {1'b0, 1'b0, {ORDER_W{1'b0}}, NIL, NIL};
				end
			end
			S_PUSH: begin
				we    = 1'b1;
				waddr = push_pg_q[PW-1:0];
				wdata = {1'b0, 1'b1, cur4, head_c, NIL};
				if (head_c < NIL) begin
					re    = 1'b1;
					raddr = head_c[PW-1:0];
				end
			end
			S_PUSH_W: begin
				we    = 1'b1;
				waddr = push_old_q[PW-1:0];
				wdata = {rd_iu, rd_fh, rd_ord, rd_nxt, push_pg_q};
			end
			S_FCHK: begin
				if (rd_iu && ord_match) begin
					we    = 1'b1;
					waddr = blk_q[PW-1:0];
					wdata = {1'b0, rd_fh, {ORDER_W{1'b0}}, rd_nxt, rd_prv};
				end
			end
			S_MERGE: begin
				if (cur_x < (OW + ORDER_W)'(MAX_ORDER) && bud < NIL) begin
					re    = 1'b1;
					raddr = bud[PW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			init_q  <= '0;
			done_q  <= 1'b0;
			for (int i = 0; i < NORD; i++) begin
				head_q[i] <= (i == MAX_ORDER) ? '0 : NIL;
				cnt_q[i]  <= (i == MAX_ORDER) ? LW'(TOP_BLOCKS) : '0;
			end
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					init_q <= init_q + PW'(1);
					if (init_l == NIL - LW'(1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						cur_q   <= inord_x[OW-1:0];
						req_q   <= inord_x[OW-1:0];
						alloc_q <= op == OP_ALLOC;
						blk_q   <= pg_l;
						bidx_q  <= '0;
						if (ord_bad) begin
							done_q   <= 1'b1;
							status_q <= ST_BAD_ORDER;
						end else if (op == OP_ALLOC) begin
							state_q <= S_SEARCH;
						end else if (pg_bad) begin
							done_q   <= 1'b1;
							status_q <= ST_NOT_ALLOC;
						end else begin
							state_q <= S_FCHK;
						end
					end
				end
				S_SEARCH: begin
					if (cur_x > (OW + ORDER_W)'(MAX_ORDER)) begin
						done_q   <= 1'b1;
						status_q <= ST_NO_MEM;
						state_q  <= S_IDLE;
					end else if (cnt_c == '0 || head_c >= NIL) begin
						cur_q <= cur_q + OW'(1);
					end else begin
						u_pg_q  <= head_c;
						blk_q   <= head_c;
						state_q <= S_UL_RD;
					end
				end
				S_UL_RD: begin
					state_q <= S_UL_A;
				end
				S_UL_A: begin
					u_prv_q <= rd_prv;
					u_nxt_q <= rd_nxt;
					if (rd_prv < NIL) begin
						state_q <= S_UL_PW;
					end else begin
						head_q[cidx] <= rd_nxt;
						state_q      <= S_UL_N;
					end
				end
				S_UL_PW: begin
					state_q <= S_UL_N;
				end
				S_UL_N: begin
					state_q <= (u_nxt_q < NIL) ? S_UL_NW : S_UL_FIN;
				end
				S_UL_NW: begin
					state_q <= S_UL_FIN;
				end
				S_UL_FIN: begin
					if (cnt_c != '0) begin
						cnt_q[cidx] <= cnt_c - LW'(1);
					end
					if (alloc_q) begin
						state_q <= S_SPLIT;
					end else begin
						blk_q   <= blk_q & u_pg_q;
						cur_q   <= cur_q + OW'(1);
						state_q <= S_MERGE;
					end
				end
				S_SPLIT: begin
					if (cur_q > req_q) begin
						cur_q     <= cur_q - OW'(1);
						push_pg_q <= blk_q + (LW'(1) << (cur_q - OW'(1)));
						state_q   <= S_PUSH;
					end else begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						bidx_q   <= blk_x[PAGE_W-1:0];
						state_q  <= S_IDLE;
					end
				end
				S_PUSH: begin
					head_q[cidx] <= push_pg_q;
					cnt_q[cidx]  <= cnt_c + LW'(1);
					push_old_q   <= head_c;
					if (head_c < NIL) begin
						state_q <= S_PUSH_W;
					end else if (alloc_q) begin
						state_q <= S_SPLIT;
					end else begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						state_q  <= S_IDLE;
					end
				end
				S_PUSH_W: begin
					if (alloc_q) begin
						state_q <= S_SPLIT;
					end else begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						state_q  <= S_IDLE;
					end
				end
				S_FCHK: begin
					if (!rd_iu) begin
						done_q   <= 1'b1;
						status_q <= ST_NOT_ALLOC;
						state_q  <= S_IDLE;
					end else if (!ord_match) begin
						done_q   <= 1'b1;
						status_q <= ST_ORDER_MISM;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_MERGE;
					end
				end
				S_MERGE: begin
					if (cur_x < (OW + ORDER_W)'(MAX_ORDER) && bud < NIL) begin
						u_pg_q  <= bud;
						state_q <= S_MCHK;
					end else begin
						push_pg_q <= blk_q;
						state_q   <= S_PUSH;
					end
				end
				S_MCHK: begin
					if (!rd_fh || rd_iu || !ord_match) begin
						push_pg_q <= blk_q;
						state_q   <= S_PUSH;
					end else begin
						state_q <= S_UL_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = state_q != S_IDLE;
	assign done        = done_q;
	assign status      = status_q;
	assign block_index = bidx_q;

	`BPA_ASSERT_NXT(a_accept_progress, clk, arst_n, start && !busy, busy || done)
	`BPA_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	`BPA_ASSERT_IMP(a_fail_zero, clk, arst_n, done && status != ST_OK, block_index == '0)
endmodule
`default_nettype wire
